@@ hw/rtl/wsd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// WebSocket deframer package
// Shared types, codes and constants of the frame deframer.
// ----------------------------------------------------------------------------
package wsd_pkg;

	localparam int QueueDepth = 4;
	localparam int QueuePtrW  = $clog2(QueueDepth);
	localparam int QueueCntW  = $clog2(QueueDepth + 1);

	localparam int PaddrW = 3;

	localparam logic [15:0] CloseStatusReset = 16'd1000;

	localparam logic [6:0] LenExt16 = 7'd126;
	localparam logic [6:0] LenExt64 = 7'd127;

	localparam logic [3:0] OpcClose = 4'd8;
	localparam logic [3:0] OpcPing  = 4'd9;

	localparam logic [7:0] ReplyCloseHdr = 8'h88;
	localparam logic [7:0] ReplyCloseLen = 8'h02;
	localparam logic [7:0] ReplyPongHdr  = 8'h8A;
	localparam logic [7:0] ReplyPongLen  = 8'h00;

	localparam logic [3:0] ExtNone = 4'd0;
	localparam logic [3:0] Ext16   = 4'd2;
	localparam logic [3:0] Ext64   = 4'd8;
	localparam logic [3:0] MaskKeyBytes = 4'd4;
	localparam logic [3:0] HdrPosMax = 4'd15;

	typedef enum logic [0:0] {
		REG_CLOSE_STATUS = 1'b0,
		REG_UNUSED       = 1'b1
	} reg_idx_t;

	typedef enum logic [1:0] {
		KIND_PAYLOAD = 2'd0,
		KIND_HEADER  = 2'd1,
		KIND_REPLY   = 2'd2,
		KIND_SHORT   = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		PRIM_NONE = 2'd0,
		PRIM_HDR  = 2'd1,
		PRIM_PAY  = 2'd2
	} prim_t;

	typedef enum logic [1:0] {
		EOF_NONE  = 2'd0,
		EOF_SHORT = 2'd1,
		EOF_CLOSE = 2'd2,
		EOF_PING  = 2'd3
	} eof_act_t;

	typedef struct packed {
		prim_t       prim;
		logic [7:0]  data;
		logic        fin;
		logic [3:0]  opcode;
		logic        masked;
		logic [63:0] length;
		eof_act_t    eof_act;
	} cmd_t;

endpackage
`default_nettype wire

@@ hw/rtl/wsd_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// WebSocket deframer stream interfaces
// Valid/ready channels for received bytes and for result words.
// ----------------------------------------------------------------------------
interface wsd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;
	logic       end_of_frame;

	modport source (output valid, output rx_byte, output end_of_frame, input ready);
	modport sink (input valid, input rx_byte, input end_of_frame, output ready);
endinterface

interface wsd_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [7:0]  data_byte;
	logic        fin_flag;
	logic [3:0]  frame_opcode;
	logic        mask_flag;
	logic [63:0] decoded_length;
	logic        last_of_run;

	modport source (output valid, output kind, output data_byte, output fin_flag,
		output frame_opcode, output mask_flag, output decoded_length,
		output last_of_run, input ready);
	modport sink (input valid, input kind, input data_byte, input fin_flag,
		input frame_opcode, input mask_flag, input decoded_length,
		input last_of_run, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/wsd_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// WebSocket deframer front end
// Parses headers, unmasks payload bytes, queues commands for the back end.
// ----------------------------------------------------------------------------
module wsd_front
	import wsd_pkg::*;
(
	input  wire         clk,
	input  wire         arst_n,
	wsd_in_if.sink      frame,
	input  wire         q_full,
	output logic        q_push,
	output cmd_t        q_cmd
);

	logic [3:0]  hdr_pos_q;
	logic        hdr_done_q;
	logic        fin_q;
	logic [3:0]  opc_q;
	logic        masked_q;
	logic [3:0]  ext_q;
	logic [63:0] len_q;
	logic [31:0] key_q;
	logic [63:0] pcount_q;

	logic [3:0]  hdr_pos_n;
	logic        hdr_done_n;
	logic        fin_n;
	logic [3:0]  opc_n;
	logic        masked_n;
	logic [3:0]  ext_n;
	logic [63:0] len_n;
	logic [31:0] key_n;
	logic [63:0] pcount_n;
	logic [4:0]  need;
	logic [7:0]  key_byte;
	logic        accept;
	logic [7:0]  b;

	assign frame.ready = !q_full;
	assign accept = frame.valid && !q_full;
	assign b = frame.rx_byte;

	always_comb begin
		hdr_pos_n  = hdr_pos_q;
		hdr_done_n = hdr_done_q;
		fin_n      = fin_q;
		opc_n      = opc_q;
		masked_n   = masked_q;
		ext_n      = ext_q;
		len_n      = len_q;
		key_n      = key_q;
		pcount_n   = pcount_q;
		need       = '0;
		q_cmd      = '0;
		q_cmd.prim = PRIM_NONE;
		q_cmd.eof_act = EOF_NONE;

		unique case (pcount_q[1:0])
			2'd0: key_byte = key_q[31:24];
			2'd1: key_byte = key_q[23:16];
			2'd2: key_byte = key_q[15:8];
			default: key_byte = key_q[7:0];
		endcase

		if (!hdr_done_q) begin
			if (hdr_pos_q == 4'd0) begin
				fin_n = b[7];
				opc_n = b[3:0];
			end else if (hdr_pos_q == 4'd1) begin
				masked_n = b[7];
				if (b[6:0] == LenExt16) begin
					ext_n = Ext16;
					len_n = '0;
				end else if (b[6:0] == LenExt64) begin
					ext_n = Ext64;
					len_n = '0;
				end else begin
					ext_n = ExtNone;
					len_n = {57'd0, b[6:0]};
				end
			end else if ({1'b0, hdr_pos_q} < 5'd2 + {1'b0, ext_q}) begin
				len_n = {len_q[55:0], b};
			end else begin
				key_n = {key_q[23:0], b};
			end
			if (hdr_pos_q < HdrPosMax) begin
				hdr_pos_n = hdr_pos_q + 4'd1;
			end
			need = 5'd2 + {1'b0, ext_n} + (masked_n ? {1'b0, MaskKeyBytes} : 5'd0);
			if (hdr_pos_q >= 4'd1 && {1'b0, hdr_pos_n} >= need) begin
				hdr_done_n    = 1'b1;
				q_cmd.prim    = PRIM_HDR;
				q_cmd.fin     = fin_n;
				q_cmd.opcode  = opc_n;
				q_cmd.masked  = masked_n;
				q_cmd.length  = len_n;
			end
		end else if (pcount_q < len_q) begin
			pcount_n   = pcount_q + 64'd1;
			q_cmd.prim = PRIM_PAY;
			q_cmd.data = masked_q ? (b ^ key_byte) : b;
		end

		if (frame.end_of_frame) begin
			if (!hdr_done_n) begin
				q_cmd.eof_act = EOF_SHORT;
			end else if (opc_n == OpcClose) begin
				q_cmd.eof_act = EOF_CLOSE;
			end else if (opc_n == OpcPing) begin
				q_cmd.eof_act = EOF_PING;
			end
			hdr_pos_n  = '0;
			hdr_done_n = 1'b0;
			fin_n      = 1'b0;
			opc_n      = '0;
			masked_n   = 1'b0;
			ext_n      = ExtNone;
			len_n      = '0;
			key_n      = '0;
			pcount_n   = '0;
		end

		q_push = accept && (q_cmd.prim != PRIM_NONE || q_cmd.eof_act != EOF_NONE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_pos_q  <= '0;
			hdr_done_q <= 1'b0;
			fin_q      <= 1'b0;
			opc_q      <= '0;
			masked_q   <= 1'b0;
			ext_q      <= ExtNone;
			len_q      <= '0;
			key_q      <= '0;
			pcount_q   <= '0;
		end else if (accept) begin
			hdr_pos_q  <= hdr_pos_n;
			hdr_done_q <= hdr_done_n;
			fin_q      <= fin_n;
			opc_q      <= opc_n;
			masked_q   <= masked_n;
			ext_q      <= ext_n;
			len_q      <= len_n;
			key_q      <= key_n;
			pcount_q   <= pcount_n;
		end
	end

endmodule
`default_nettype wire

@@ hw/rtl/wsd_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// WebSocket deframer command queue
// Small first-in first-out buffer between the front end and the back end.
// ----------------------------------------------------------------------------
module wsd_queue
	import wsd_pkg::*;
(
	input  wire         clk,
	input  wire         arst_n,
	input  wire         push,
	input  cmd_t        push_cmd,
	output logic        full,
	input  wire         pop,
	output cmd_t        head,
	output logic        empty
);

	cmd_t                 entries_q [QueueDepth];
	logic [QueuePtrW-1:0] wr_ptr_q;
	logic [QueuePtrW-1:0] rd_ptr_q;
	logic [QueueCntW-1:0] cnt_q;
	logic                 do_push;
	logic                 do_pop;

	assign full    = cnt_q == QueueCntW'(QueueDepth);
	assign empty   = cnt_q == '0;
	assign head    = entries_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + QueuePtrW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QueuePtrW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + QueueCntW'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - QueueCntW'(1);
			end
		end
	end

endmodule
`default_nettype wire

@@ hw/rtl/wsd_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// WebSocket deframer back end
// Expands each queued command into its result words through an output register.
// ----------------------------------------------------------------------------
module wsd_back
	import wsd_pkg::*;
(
	input  wire         clk,
	input  wire         arst_n,
	input  cmd_t        head,
	input  wire         empty,
	output logic        pop,
	input  wire  [15:0] close_status,
	wsd_out_if.source   result
);

	logic [2:0]  idx_q;
	logic        out_valid_q;
	kind_t       kind_q;
	logic [7:0]  data_q;
	logic        fin_q;
	logic [3:0]  opc_q;
	logic        mask_q;
	logic [63:0] len_q;
	logic        last_q;

	logic        load;
	logic        has_prim;
	logic [2:0]  eof_cnt;
	logic [2:0]  total;
	logic [2:0]  r;
	logic        last;
	kind_t       kind_n;
	logic [7:0]  data_n;
	logic        fin_n;
	logic [3:0]  opc_n;
	logic        mask_n;
	logic [63:0] len_n;

	assign load = !empty && (!out_valid_q || result.ready);

	always_comb begin
		has_prim = head.prim != PRIM_NONE;
		unique case (head.eof_act)
			EOF_NONE:  eof_cnt = 3'd0;
			EOF_SHORT: eof_cnt = 3'd1;
			EOF_CLOSE: eof_cnt = 3'd4;
			EOF_PING:  eof_cnt = 3'd2;
		endcase
		total = {2'd0, has_prim} + eof_cnt;
		last  = idx_q == total - 3'd1;
		r     = idx_q - {2'd0, has_prim};

		kind_n = KIND_REPLY;
		data_n = '0;
		fin_n  = 1'b0;
		opc_n  = '0;
		mask_n = 1'b0;
		len_n  = '0;

		if (has_prim && idx_q == 3'd0) begin
			if (head.prim == PRIM_HDR) begin
				kind_n = KIND_HEADER;
				fin_n  = head.fin;
				opc_n  = head.opcode;
				mask_n = head.masked;
				len_n  = head.length;
			end else begin
				kind_n = KIND_PAYLOAD;
				data_n = head.data;
			end
		end else begin
			unique case (head.eof_act)
				EOF_NONE: begin
					kind_n = KIND_REPLY;
				end
				EOF_SHORT: begin
					kind_n = KIND_SHORT;
				end
				EOF_CLOSE: begin
					unique case (r[1:0])
						2'd0: data_n = ReplyCloseHdr;
						2'd1: data_n = ReplyCloseLen;
						2'd2: data_n = close_status[15:8];
						default: data_n = close_status[7:0];
					endcase
				end
				EOF_PING: begin
					data_n = (r == 3'd0) ? ReplyPongHdr : ReplyPongLen;
				end
			endcase
		end

		pop = load && last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= '0;
		end else begin
			if (!out_valid_q || result.ready) begin
				out_valid_q <= !empty;
			end
			if (load) begin
				idx_q <= last ? 3'd0 : idx_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			kind_q <= kind_n;
			data_q <= data_n;
			fin_q  <= fin_n;
			opc_q  <= opc_n;
			mask_q <= mask_n;
			len_q  <= len_n;
			last_q <= last;
		end
	end

	assign result.valid          = out_valid_q;
	assign result.kind           = kind_q;
	assign result.data_byte      = data_q;
	assign result.fin_flag       = fin_q;
	assign result.frame_opcode   = opc_q;
	assign result.mask_flag      = mask_q;
	assign result.decoded_length = len_q;
	assign result.last_of_run    = last_q;

endmodule
`default_nettype wire

@@ hw/rtl/websocket_frame_deframer_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// WebSocket frame deframer core
// Receive-side frame parser with unmasking and ping/close replies.
// ----------------------------------------------------------------------------
// The block takes one frame byte per cycle while its four-entry command queue
// has room, and delivers one result word per cycle while the sink is ready.
// The completed header or a payload byte yields one word, and the last byte of
// a frame adds one word for a short frame, two for a pong reply or four for a
// close reply, so a frame-end byte yields up to five words; the output register
// and its one-word-per-cycle drain set the sustained rate. The close status
// register sits at byte address 0 of the APB port.
module websocket_frame_deframer_core
	import wsd_pkg::*;
(
	input  wire               clk,
	input  wire               arst_n,
	input  wire               psel,
	input  wire               penable,
	input  wire               pwrite,
	input  wire  [PaddrW-1:0] paddr,
	input  wire  [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	wsd_in_if.sink            frame,
	wsd_out_if.source         result
);

	logic [15:0] close_status_q;
	reg_idx_t    reg_idx;
	logic        q_push;
	logic        q_pop;
	logic        q_full;
	logic        q_empty;
	cmd_t        q_cmd;
	cmd_t        q_head;

	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[2]);

	always_comb begin
		unique case (reg_idx)
			REG_CLOSE_STATUS: prdata = {16'd0, close_status_q};
			REG_UNUSED:       prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			close_status_q <= CloseStatusReset;
		end else if (psel && penable && pwrite && reg_idx == REG_CLOSE_STATUS) begin
			close_status_q <= pwdata[15:0];
		end
	end

	wsd_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.frame  (frame),
		.q_full (q_full),
		.q_push (q_push),
		.q_cmd  (q_cmd)
	);

	wsd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (q_cmd),
		.full     (q_full),
		.pop      (q_pop),
		.head     (q_head),
		.empty    (q_empty)
	);

	wsd_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (q_head),
		.empty        (q_empty),
		.pop          (q_pop),
		.close_status (close_status_q),
		.result       (result)
	);

endmodule
`default_nettype wire
